[rtl/core/prmq_pkg.sv]
package prmq_pkg;

  localparam int unsigned QueueDepthDef = 32;
  localparam int unsigned NumCoresDef   = 64;
  localparam int unsigned NumKindsDef   = 16;

  typedef enum logic [2:0] {
    OUT_HANDLER = 3'd0,
    OUT_MATCHED = 3'd1,
    OUT_QUEUED  = 3'd2,
    OUT_PENDING = 3'd3,
    OUT_DROPPED = 3'd4
  } outcome_e;

  typedef struct packed {
    logic        req_type;
    logic [5:0]  pkt_sender;
    logic [3:0]  pkt_kind;
    logic [15:0] pkt_tag;
    logic [63:0] want_senders;
    logic [15:0] want_kinds;
  } in_item_t;

  typedef struct packed {
    outcome_e    outcome;
    logic [5:0]  got_sender;
    logic [3:0]  got_kind;
    logic [15:0] got_tag;
    logic [5:0]  fill_level;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic commit;
  } dp_cmd_t;

endpackage

[rtl/core/prmq_ctrl.sv]
module prmq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output prmq_pkg::dp_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d      = state_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    cmd_o.load   = 1'b0;
    cmd_o.commit = 1'b0;
    in_ready_o   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // result lands only when the output register is free or being emptied
        if (!out_valid_q || out_ready_i) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[rtl/core/prmq_dp.sv]
module prmq_dp #(
  parameter int unsigned QUEUE_DEPTH = prmq_pkg::QueueDepthDef,
  parameter int unsigned NUM_CORES   = prmq_pkg::NumCoresDef,
  parameter int unsigned NUM_KINDS   = prmq_pkg::NumKindsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  prmq_pkg::dp_cmd_t   cmd_i,
  input  prmq_pkg::in_item_t  in_item_i,
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_wdata_i,
  output prmq_pkg::out_item_t out_item_o
);

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [5:0]  sender;
    logic [3:0]  kind;
    logic [15:0] tag;
  } entry_t;

  function automatic logic entry_match(logic [5:0] s, logic [3:0] k,
                                       logic [63:0] sm, logic [15:0] km);
    logic ok;
    ok = (32'(s) < NUM_CORES) && (32'(k) < NUM_KINDS);
    if (sm != '0 && !sm[s]) ok = 1'b0;
    if (km != '0 && !km[k]) ok = 1'b0;
    return ok;
  endfunction

  prmq_pkg::in_item_t  in_q;
  prmq_pkg::out_item_t out_q, res;
  logic [15:0]         hmask_q;

  entry_t              cells_q [QUEUE_DEPTH];
  entry_t              cells_d [QUEUE_DEPTH];
  logic [CntW-1:0]     count_q, count_d;
  logic                pend_q, pend_d;
  logic [63:0]         pend_send_q, pend_send_d;
  logic [15:0]         pend_kind_q, pend_kind_d;

  logic [QUEUE_DEPTH-1:0] hit, first, from_first;
  entry_t                 pick, arr;
  logic                   handler, arr_hit, full;

  // every held entry is checked against the request at once
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      hit[i] = (CntW'(i) < count_q) &&
               entry_match(cells_q[i].sender, cells_q[i].kind,
                           in_q.want_senders, in_q.want_kinds);
    end
  end

  assign first      = hit & (~hit + QUEUE_DEPTH'(1));
  assign from_first = ~(first - QUEUE_DEPTH'(1));

  always_comb begin
    pick = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (first[i]) pick = pick | cells_q[i];
    end
  end

  assign arr.sender = in_q.pkt_sender;
  assign arr.kind   = in_q.pkt_kind;
  assign arr.tag    = in_q.pkt_tag;

  assign handler = (32'(in_q.pkt_kind) < NUM_KINDS) && hmask_q[in_q.pkt_kind];
  // a pending request never matches an entry already held, only the new arrival
  assign arr_hit = pend_q && entry_match(in_q.pkt_sender, in_q.pkt_kind,
                                         pend_send_q, pend_kind_q);
  assign full    = (count_q == CntW'(QUEUE_DEPTH));

  always_comb begin
    cells_d     = cells_q;
    count_d     = count_q;
    pend_d      = pend_q;
    pend_send_d = pend_send_q;
    pend_kind_d = pend_kind_q;
    res         = '0;
    res.outcome = prmq_pkg::OUT_QUEUED;
    if (!in_q.req_type) begin
      if (handler) begin
        res.outcome    = prmq_pkg::OUT_HANDLER;
        res.got_sender = arr.sender;
        res.got_kind   = arr.kind;
        res.got_tag    = arr.tag;
      end else if (arr_hit) begin
        res.outcome    = prmq_pkg::OUT_MATCHED;
        res.got_sender = arr.sender;
        res.got_kind   = arr.kind;
        res.got_tag    = arr.tag;
        pend_d         = 1'b0;
        pend_send_d    = '0;
        pend_kind_d    = '0;
      end else if (full) begin
        res.outcome = prmq_pkg::OUT_DROPPED;
      end else begin
        res.outcome = prmq_pkg::OUT_QUEUED;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
          if (count_q == CntW'(i)) cells_d[i] = arr;
        end
        count_d = count_q + CntW'(1);
      end
    end else begin
      if (|hit) begin
        res.outcome    = prmq_pkg::OUT_MATCHED;
        res.got_sender = pick.sender;
        res.got_kind   = pick.kind;
        res.got_tag    = pick.tag;
        // close the gap: every cell from the picked one up takes its upper neighbor
        for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
          if (from_first[i]) cells_d[i] = cells_q[i+1];
        end
        count_d     = count_q - CntW'(1);
        pend_d      = 1'b0;
        pend_send_d = '0;
        pend_kind_d = '0;
      end else begin
        res.outcome = prmq_pkg::OUT_PENDING;
        pend_d      = 1'b1;
        pend_send_d = in_q.want_senders;
        pend_kind_d = in_q.want_kinds;
      end
    end
    res.fill_level = 6'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hmask_q     <= '0;
      count_q     <= '0;
      pend_q      <= 1'b0;
      pend_send_q <= '0;
      pend_kind_q <= '0;
    end else begin
      if (cfg_we_i) hmask_q <= cfg_wdata_i;
      if (cmd_i.commit) begin
        count_q     <= count_d;
        pend_q      <= pend_d;
        pend_send_q <= pend_send_d;
        pend_kind_q <= pend_kind_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) in_q <= in_item_i;
    if (cmd_i.commit) begin
      cells_q <= cells_d;
      out_q   <= res;
    end
  end

  assign out_item_o = out_q;

endmodule

[rtl/core/packet_receive_match_queue.sv]
// Receive-side matching engine. Each item is an arrival (sender, kind, tag) or a posted
// receive request (sender mask, kind mask, zero meaning any); each item gives exactly one
// result with its outcome, the delivered packet where there is one, and the fill level.
// Arrivals whose kind is enabled in the handler mask go straight out; others satisfy a
// pending request or are appended to a store of QUEUE_DEPTH entries, or are dropped when
// it is full. A request takes the oldest matching entry and the store compacts at once.
// An item is captured first; then all held entries are compared in parallel, the oldest
// hit is picked and the store is compacted. The compare step waits while the result
// register holds an item that is not being taken, so a stalled output holds it back. The
// handler mask is written through cfg_we_i at any idle time.
module packet_receive_match_queue #(
  parameter int unsigned QUEUE_DEPTH = prmq_pkg::QueueDepthDef,
  parameter int unsigned NUM_CORES   = prmq_pkg::NumCoresDef,
  parameter int unsigned NUM_KINDS   = prmq_pkg::NumKindsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  prmq_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output prmq_pkg::out_item_t out_item_o,
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_wdata_i
);

  prmq_pkg::dp_cmd_t cmd;

  prmq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  prmq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .NUM_CORES   (NUM_CORES),
    .NUM_KINDS   (NUM_KINDS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_item_i   (in_item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_item_o  (out_item_o)
  );

`ifndef SYNTHESIS
  // one item at a time: no second item right after an accepted one
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("item accepted while another is in progress");

  a_no_packet_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.outcome == prmq_pkg::OUT_QUEUED ||
                    out_item_o.outcome == prmq_pkg::OUT_PENDING ||
                    out_item_o.outcome == prmq_pkg::OUT_DROPPED)
    |-> out_item_o.got_sender == '0 && out_item_o.got_kind == '0 &&
        out_item_o.got_tag == '0)
    else $error("packet fields set on a result without delivery");

  a_handler_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.outcome == prmq_pkg::OUT_HANDLER
    |-> 32'(out_item_o.got_kind) < NUM_KINDS)
    else $error("handler delivery of an out-of-range kind");
`endif

endmodule
